FILE: hw/rtl/sha256_pkg.sv
// SHA-256 byte-stream hasher: shared types, constants and round functions.
// No dependencies; used by every file in hw/rtl except sha256_checker.
`timescale 1ns / 1ps

package sha256_pkg;

    // One request from the byte packer to the compression engine.
    typedef struct packed {
        logic        last;
        logic [2:0]  nbytes;
        logic [31:0] data;
    } sha256_cmd_t;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } sha256_state_t;

    localparam logic [2:0]  FULL_WORD_BYTES = 3'd4;
    localparam logic [31:0] PAD_MARK_WORD   = 32'h8000_0000;
    localparam logic [7:0]  PAD_MARK_BYTE   = 8'h80;
    localparam logic [3:0]  LAST_LEN_SLOT   = 4'd13;
    localparam logic [3:0]  LEN_HI_SLOT     = 4'd14;
    localparam logic [3:0]  LEN_LO_SLOT     = 4'd15;
    localparam logic [5:0]  LAST_ROUND      = 6'd63;
    localparam logic [2:0]  LAST_DIGEST     = 3'd7;

    function automatic logic [31:0] sha256_iv(input logic [2:0] idx);
        logic [31:0] val;
        begin
            unique case (idx)
                3'd0: val = 32'h6A09E667;
                3'd1: val = 32'hBB67AE85;
                3'd2: val = 32'h3C6EF372;
                3'd3: val = 32'hA54FF53A;
                3'd4: val = 32'h510E527F;
                3'd5: val = 32'h9B05688C;
                3'd6: val = 32'h1F83D9AB;
                3'd7: val = 32'h5BE0CD19;
                default: val = 32'h6A09E667;
            endcase
            return val;
        end
    endfunction

    function automatic logic [31:0] sha256_k(input logic [5:0] idx);
        logic [31:0] val;
        begin
            unique case (idx)
                6'd0:  val = 32'h428A2F98;
                6'd1:  val = 32'h71374491;
                6'd2:  val = 32'hB5C0FBCF;
                6'd3:  val = 32'hE9B5DBA5;
                6'd4:  val = 32'h3956C25B;
                6'd5:  val = 32'h59F111F1;
                6'd6:  val = 32'h923F82A4;
                6'd7:  val = 32'hAB1C5ED5;
                6'd8:  val = 32'hD807AA98;
                6'd9:  val = 32'h12835B01;
                6'd10: val = 32'h243185BE;
                6'd11: val = 32'h550C7DC3;
                6'd12: val = 32'h72BE5D74;
                6'd13: val = 32'h80DEB1FE;
                6'd14: val = 32'h9BDC06A7;
                6'd15: val = 32'hC19BF174;
                6'd16: val = 32'hE49B69C1;
                6'd17: val = 32'hEFBE4786;
                6'd18: val = 32'h0FC19DC6;
                6'd19: val = 32'h240CA1CC;
                6'd20: val = 32'h2DE92C6F;
                6'd21: val = 32'h4A7484AA;
                6'd22: val = 32'h5CB0A9DC;
                6'd23: val = 32'h76F988DA;
                6'd24: val = 32'h983E5152;
                6'd25: val = 32'hA831C66D;
                6'd26: val = 32'hB00327C8;
                6'd27: val = 32'hBF597FC7;
                6'd28: val = 32'hC6E00BF3;
                6'd29: val = 32'hD5A79147;
                6'd30: val = 32'h06CA6351;
                6'd31: val = 32'h14292967;
                6'd32: val = 32'h27B70A85;
                6'd33: val = 32'h2E1B2138;
                6'd34: val = 32'h4D2C6DFC;
                6'd35: val = 32'h53380D13;
                6'd36: val = 32'h650A7354;
                6'd37: val = 32'h766A0ABB;
                6'd38: val = 32'h81C2C92E;
                6'd39: val = 32'h92722C85;
                6'd40: val = 32'hA2BFE8A1;
                6'd41: val = 32'hA81A664B;
                6'd42: val = 32'hC24B8B70;
                6'd43: val = 32'hC76C51A3;
                6'd44: val = 32'hD192E819;
                6'd45: val = 32'hD6990624;
                6'd46: val = 32'hF40E3585;
                6'd47: val = 32'h106AA070;
                6'd48: val = 32'h19A4C116;
                6'd49: val = 32'h1E376C08;
                6'd50: val = 32'h2748774C;
                6'd51: val = 32'h34B0BCB5;
                6'd52: val = 32'h391C0CB3;
                6'd53: val = 32'h4ED8AA4A;
                6'd54: val = 32'h5B9CCA4F;
                6'd55: val = 32'h682E6FF3;
                6'd56: val = 32'h748F82EE;
                6'd57: val = 32'h78A5636F;
                6'd58: val = 32'h84C87814;
                6'd59: val = 32'h8CC70208;
                6'd60: val = 32'h90BEFFFA;
                6'd61: val = 32'hA4506CEB;
                6'd62: val = 32'hBEF9A3F7;
                6'd63: val = 32'hC67178F2;
                default: val = 32'h428A2F98;
            endcase
            return val;
        end
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        begin
            return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
        end
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        begin
            return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
        end
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        begin
            return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
        end
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        begin
            return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
        end
    endfunction

endpackage

FILE: hw/rtl/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte-stream hasher.
// Instantiates sha256_front, sha256_cmd_fifo and sha256_back; uses sha256_pkg.
//
// Channel   Direction  Handshake          Payload
// input     in         push / full        data_byte, byte_present, message_end
// result    out        pop / empty        digest_word, word_number, final_word
//
// The packer takes one byte per cycle while full is low and hands a request to the
// queue per four bytes or at a message end. Each 64-byte block is loaded into the
// engine as 16 words, then runs 64 rounds and folds the result into the chaining words.
// The end of a message adds the padding words and one or two block compressions,
// then eight digest words leave at up to one per cycle.
// Reset leaves the block ready for a new message; full rises when the request queue fills.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher
#(
    parameter int CMD_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        message_end,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] digest_word,
    output logic [2:0]  word_number,
    output logic        final_word
);

    sha256_pkg::sha256_cmd_t wr_cmd;
    sha256_pkg::sha256_cmd_t rd_cmd;
    logic                    cmd_push;
    logic                    cmd_full;
    logic                    cmd_pop;
    logic                    cmd_valid;

    sha256_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .message_end  (message_end),
        .cmd_full     (cmd_full),
        .cmd_push     (cmd_push),
        .cmd          (wr_cmd)
    );

    sha256_cmd_fifo #(.DEPTH(CMD_DEPTH)) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (cmd_push),
        .wr_data    (wr_cmd),
        .fifo_full  (cmd_full),
        .rd_en      (cmd_pop),
        .rd_data    (rd_cmd),
        .fifo_valid (cmd_valid)
    );

    sha256_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (rd_cmd),
        .cmd_pop     (cmd_pop),
        .empty       (empty),
        .pop         (pop),
        .digest_word (digest_word),
        .word_number (word_number),
        .final_word  (final_word)
    );

endmodule

FILE: hw/rtl/sha256_front.sv
// Byte packer: gathers message bytes into big-endian 32-bit words and issues
// word and end-of-message requests. Depends on sha256_pkg.
`timescale 1ns / 1ps

module sha256_front
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [7:0]              data_byte,
    input  logic                    byte_present,
    input  logic                    message_end,
    input  logic                    cmd_full,
    output logic                    cmd_push,
    output sha256_pkg::sha256_cmd_t cmd
);

    logic [31:0] word_reg;
    logic [31:0] word_next;
    logic [1:0]  bcnt_reg;
    logic [1:0]  bcnt_next;
    logic [2:0]  bcnt_plus;
    logic        accept;

    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    always_comb
    begin
        word_next  = byte_present ? {word_reg[23:0], data_byte} : word_reg;
        bcnt_plus  = {1'b0, bcnt_reg} + {2'b00, byte_present};
        bcnt_next  = bcnt_reg;
        cmd_push   = 1'b0;
        cmd.last   = message_end;
        cmd.nbytes = bcnt_plus;
        cmd.data   = word_next;
        if (accept)
        begin
            if ((bcnt_plus == sha256_pkg::FULL_WORD_BYTES) || message_end)
            begin
                cmd_push  = 1'b1;
                bcnt_next = 2'd0;
            end
            else
            begin
                bcnt_next = bcnt_plus[1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcnt_reg <= 2'd0;
        end
        else
        begin
            bcnt_reg <= bcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= word_next;
        end
    end

endmodule

FILE: hw/rtl/sha256_cmd_fifo.sv
// Short request queue between the byte packer and the compression engine.
// Depends on sha256_pkg for the request type.
`timescale 1ns / 1ps

module sha256_cmd_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  sha256_pkg::sha256_cmd_t wr_data,
    output logic                    fifo_full,
    input  logic                    rd_en,
    output sha256_pkg::sha256_cmd_t rd_data,
    output logic                    fifo_valid
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sha256_pkg::sha256_cmd_t mem_reg [DEPTH];
    logic [AW-1:0] wptr_reg;
    logic [AW-1:0] wptr_next;
    logic [AW-1:0] rptr_reg;
    logic [AW-1:0] rptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_wr;
    logic          do_rd;

    assign fifo_full  = (count_reg == CW'(DEPTH));
    assign fifo_valid = (count_reg != '0);
    assign do_wr      = wr_en && !fifo_full;
    assign do_rd      = rd_en && fifo_valid;
    assign rd_data    = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_wr)
        begin
            wptr_next = (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rptr_next = (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

FILE: hw/rtl/sha256_back.sv
// Compression engine: message schedule, padding sequencer, 64-round core and
// the digest output register. Depends on sha256_pkg.
`timescale 1ns / 1ps

module sha256_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    input  sha256_pkg::sha256_cmd_t cmd,
    output logic                    cmd_pop,
    output logic                    empty,
    input  logic                    pop,
    output logic [31:0]             digest_word,
    output logic [2:0]              word_number,
    output logic                    final_word
);

    sha256_pkg::sha256_state_t state_reg;
    sha256_pkg::sha256_state_t state_next;

    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] hash_reg [8];
    logic [63:0] len_reg;
    logic [63:0] len_next;
    logic [63:0] len_add;
    logic [3:0]  wcnt_reg;
    logic [3:0]  wcnt_next;
    logic [5:0]  rcnt_reg;
    logic [5:0]  rcnt_next;
    logic [2:0]  ocnt_reg;
    logic [2:0]  ocnt_next;
    logic        need80_reg;
    logic        need80_next;
    logic        ending_reg;
    logic        ending_next;
    logic        len_ok_reg;
    logic        len_ok_next;
    logic        final_blk_reg;
    logic        final_blk_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] out_word_reg;
    logic [2:0]  out_num_reg;
    logic        out_final_reg;

    logic        do_insert;
    logic        do_round;
    logic        do_add;
    logic        start_comp;
    logic        load_out;
    logic        clear_msg;
    logic        out_pop;
    logic [31:0] ins_word;
    logic [31:0] pad_word;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] w_new;

    assign empty       = !out_valid_reg;
    assign digest_word = out_word_reg;
    assign word_number = out_num_reg;
    assign final_word  = out_final_reg;
    assign out_pop     = pop && out_valid_reg;

    always_comb
    begin
        unique case (cmd.nbytes[1:0])
            2'd0: pad_word = sha256_pkg::PAD_MARK_WORD;
            2'd1: pad_word = {cmd.data[7:0], sha256_pkg::PAD_MARK_BYTE, 16'd0};
            2'd2: pad_word = {cmd.data[15:0], sha256_pkg::PAD_MARK_BYTE, 8'd0};
            2'd3: pad_word = {cmd.data[23:0], sha256_pkg::PAD_MARK_BYTE};
            default: pad_word = sha256_pkg::PAD_MARK_WORD;
        endcase
    end

    always_comb
    begin
        t1 = v_reg[7] + sha256_pkg::big_sigma1(v_reg[4])
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + sha256_pkg::sha256_k(rcnt_reg) + w_reg[0];
        t2 = sha256_pkg::big_sigma0(v_reg[0])
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        w_new = sha256_pkg::small_sigma1(w_reg[14]) + w_reg[9]
              + sha256_pkg::small_sigma0(w_reg[1]) + w_reg[0];
    end

    always_comb
    begin
        state_next     = state_reg;
        wcnt_next      = wcnt_reg;
        rcnt_next      = rcnt_reg;
        ocnt_next      = ocnt_reg;
        need80_next    = need80_reg;
        ending_next    = ending_reg;
        len_ok_next    = len_ok_reg;
        final_blk_next = final_blk_reg;
        len_add        = 64'd0;
        ins_word       = 32'd0;
        do_insert      = 1'b0;
        do_round       = 1'b0;
        do_add         = 1'b0;
        start_comp     = 1'b0;
        load_out       = 1'b0;
        clear_msg      = 1'b0;
        cmd_pop        = 1'b0;

        unique case (state_reg)
            sha256_pkg::ST_COLLECT:
            begin
                if (cmd_valid)
                begin
                    cmd_pop   = 1'b1;
                    do_insert = 1'b1;
                    if (cmd.nbytes == sha256_pkg::FULL_WORD_BYTES)
                    begin
                        ins_word = cmd.data;
                        len_add  = 64'd32;
                    end
                    else
                    begin
                        ins_word    = pad_word;
                        len_add     = {58'd0, cmd.nbytes, 3'b000};
                        len_ok_next = (wcnt_reg <= sha256_pkg::LAST_LEN_SLOT);
                    end
                    if (cmd.last)
                    begin
                        ending_next = 1'b1;
                        need80_next = (cmd.nbytes == sha256_pkg::FULL_WORD_BYTES);
                        state_next  = sha256_pkg::ST_PAD;
                    end
                end
            end
            sha256_pkg::ST_PAD:
            begin
                do_insert = 1'b1;
                if (need80_reg)
                begin
                    ins_word    = sha256_pkg::PAD_MARK_WORD;
                    need80_next = 1'b0;
                    len_ok_next = (wcnt_reg <= sha256_pkg::LAST_LEN_SLOT);
                end
                else if (len_ok_reg && (wcnt_reg == sha256_pkg::LEN_HI_SLOT))
                begin
                    ins_word = len_reg[63:32];
                end
                else if (len_ok_reg && (wcnt_reg == sha256_pkg::LEN_LO_SLOT))
                begin
                    ins_word       = len_reg[31:0];
                    final_blk_next = 1'b1;
                end
                else
                begin
                    ins_word = 32'd0;
                end
            end
            sha256_pkg::ST_ROUND:
            begin
                do_round  = 1'b1;
                rcnt_next = rcnt_reg + 1'b1;
                if (rcnt_reg == sha256_pkg::LAST_ROUND)
                begin
                    state_next = sha256_pkg::ST_ADD;
                end
            end
            sha256_pkg::ST_ADD:
            begin
                do_add = 1'b1;
                if (final_blk_reg)
                begin
                    state_next = sha256_pkg::ST_OUT;
                end
                else if (ending_reg)
                begin
                    state_next = sha256_pkg::ST_PAD;
                end
                else
                begin
                    state_next = sha256_pkg::ST_COLLECT;
                end
            end
            sha256_pkg::ST_OUT:
            begin
                if (!out_valid_reg || pop)
                begin
                    load_out  = 1'b1;
                    ocnt_next = ocnt_reg + 1'b1;
                    if (ocnt_reg == sha256_pkg::LAST_DIGEST)
                    begin
                        clear_msg      = 1'b1;
                        need80_next    = 1'b0;
                        ending_next    = 1'b0;
                        len_ok_next    = 1'b0;
                        final_blk_next = 1'b0;
                        state_next     = sha256_pkg::ST_COLLECT;
                    end
                end
            end
            default:
            begin
                state_next = sha256_pkg::ST_COLLECT;
            end
        endcase

        if (do_insert)
        begin
            wcnt_next = wcnt_reg + 1'b1;
            if (wcnt_reg == sha256_pkg::LEN_LO_SLOT)
            begin
                start_comp = 1'b1;
                rcnt_next  = 6'd0;
                state_next = sha256_pkg::ST_ROUND;
                if (ending_next)
                begin
                    len_ok_next = 1'b1;
                end
            end
        end

        len_next = clear_msg ? 64'd0 : len_reg + len_add;

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha256_pkg::ST_COLLECT;
            wcnt_reg      <= 4'd0;
            rcnt_reg      <= 6'd0;
            ocnt_reg      <= 3'd0;
            need80_reg    <= 1'b0;
            ending_reg    <= 1'b0;
            len_ok_reg    <= 1'b0;
            final_blk_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            len_reg       <= 64'd0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= sha256_pkg::sha256_iv(3'(i));
            end
        end
        else
        begin
            state_reg     <= state_next;
            wcnt_reg      <= wcnt_next;
            rcnt_reg      <= rcnt_next;
            ocnt_reg      <= ocnt_next;
            need80_reg    <= need80_next;
            ending_reg    <= ending_next;
            len_ok_reg    <= len_ok_next;
            final_blk_reg <= final_blk_next;
            out_valid_reg <= out_valid_next;
            len_reg       <= len_next;
            for (int i = 0; i < 8; i++)
            begin
                if (do_add)
                begin
                    hash_reg[i] <= hash_reg[i] + v_reg[i];
                end
                else if (clear_msg)
                begin
                    hash_reg[i] <= sha256_pkg::sha256_iv(3'(i));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_insert || do_round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= do_insert ? ins_word : w_new;
        end
        if (start_comp)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= hash_reg[i];
            end
        end
        else if (do_round)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        if (load_out)
        begin
            out_word_reg  <= hash_reg[ocnt_reg];
            out_num_reg   <= ocnt_reg;
            out_final_reg <= (ocnt_reg == sha256_pkg::LAST_DIGEST);
        end
    end

endmodule

FILE: hw/rtl/sha256_checker.sv
// Port-level checks on the digest output of the SHA-256 byte-stream hasher.
// Attached to sha256_byte_stream_hasher by the bind statement at the end.
`timescale 1ns / 1ps

module sha256_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [31:0] digest_word,
    input logic [2:0]  word_number,
    input logic        final_word
);

    // A stalled result stays on the ports unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(digest_word) && $stable(word_number)))
    else $error("stalled digest word changed");

    // The last-word flag marks exactly the eighth word.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (final_word == (word_number == 3'd7)))
    else $error("final_word does not match word_number");

    // Digest words follow each other without a gap and in order.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !final_word) |=>
            (!empty && (word_number == 3'($past(word_number) + 3'd1))))
    else $error("digest words out of order");

    // After the last word is taken, no result is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && final_word) |=> empty)
    else $error("result present right after the final digest word");

endmodule

bind sha256_byte_stream_hasher sha256_checker u_sha256_checker (.*);
